// File: hw/rtl/tpbd_pkg.sv
// shared types, constants and colour helpers for the texture pixel block decoder
`timescale 1ns / 1ps
`default_nettype none

package tpbd_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int COORD_W    = 12;
    localparam int BLOCK_SIZE = 4;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam logic [2:0] MODE_RGB555     = 3'd0;
    localparam logic [2:0] MODE_RGBA4444   = 3'd1;
    localparam logic [2:0] MODE_BGRA8888   = 3'd2;
    localparam logic [2:0] MODE_BLOCK      = 3'd3;
    localparam logic [2:0] MODE_BLOCK_ALPHA = 3'd4;

    // one queued beat of work: a raster pixel or one block row of up to four pixels
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [23:0]        c1;
        logic [23:0]        c2;
        logic [7:0]         idx;
        logic [7:0]         a_lo;
        logic [7:0]         a_hi;
        logic [1:0]         last_lane;
        logic               done;
    } t_job;

    function automatic logic [7:0] exp5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] exp6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [7:0] exp4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [23:0] rgb565(input logic [15:0] v);
        return {exp5(v[15:11]), exp6(v[10:5]), exp5(v[4:0])};
    endfunction

    function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + 9'd1;
        return s[8:1];
    endfunction

    function automatic logic [4:0] item_len(input logic [2:0] mode);
        logic [4:0] l;
        case (mode)
            MODE_RGB555:      l = 5'd2;
            MODE_RGBA4444:    l = 5'd2;
            MODE_BGRA8888:    l = 5'd4;
            MODE_BLOCK:       l = 5'd8;
            MODE_BLOCK_ALPHA: l = 5'd16;
            default:          l = 5'd0;
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tpbd_front.sv
// byte parser: configuration, phase and position tracking, job generation
`timescale 1ns / 1ps
`default_nettype none

module tpbd_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [12:0]          i_cfg_data,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_first_byte,
    output logic                      o_push,
    output tpbd_pkg::t_job            o_job
);

    localparam int DW = tpbd_pkg::DIM_W;

    logic [2:0]    r_mode;
    logic [DW-1:0] r_width, r_height;
    logic [4:0]    r_phase, n_phase;
    logic [7:0]    r_low, r_mid, r_high, n_low, n_mid, n_high;
    logic [DW-1:0] r_col, r_row, n_col, n_row;
    logic          r_fin, n_fin;
    logic [15:0]   r_ep1, r_ep2;
    logic [15:0]   r_alpha [4];

    logic [DW-1:0] w, h, col0, row0;
    logic          fin0;
    logic [4:0]    len, ph0, ph, off, base;
    logic [5:0]    ph_inc;
    logic          with_alpha;
    logic [3:0]    ep_we;
    logic          alpha_we;
    logic [1:0]    brow;
    logic          raster_go, block_go;
    logic [7:0]    rr, rg, rb, ra;
    logic [15:0]   word;
    logic [DW:0]   px, py;
    logic [DW:0]   ncol, nrow;
    logic [3:0]    mask;
    logic          hit;
    logic          raster_emit, raster_done;
    logic [2:0]    cnt;

    always_comb begin
        w = (r_width > DW'(tpbd_pkg::MAX_DIM)) ? DW'(tpbd_pkg::MAX_DIM) : r_width;
        h = (r_height > DW'(tpbd_pkg::MAX_DIM)) ? DW'(tpbd_pkg::MAX_DIM) : r_height;
        col0 = i_first_byte ? '0 : r_col;
        row0 = i_first_byte ? '0 : r_row;
        fin0 = i_first_byte ? 1'b0 : r_fin;
        ph0  = i_first_byte ? '0 : r_phase;
        len  = tpbd_pkg::item_len(r_mode);
        ph   = (ph0 >= len) ? '0 : ph0;
        ph_inc = {1'b0, ph} + 6'd1;
        n_phase = (len == '0 || ph_inc >= {1'b0, len}) ? '0 : ph_inc[4:0];

        with_alpha = (r_mode == tpbd_pkg::MODE_BLOCK_ALPHA);
        base = with_alpha ? 5'd8 : 5'd0;
        off  = ph - base;
        brow = off[1:0];

        n_low = r_low; n_mid = r_mid; n_high = r_high;
        n_col = col0; n_row = row0; n_fin = fin0;
        ep_we = '0;
        alpha_we = 1'b0;
        raster_go = 1'b0;
        block_go  = 1'b0;
        word = {i_data_byte, r_low};
        rr = '0; rg = '0; rb = '0; ra = '0;

        case (r_mode)
            tpbd_pkg::MODE_RGB555: begin
                if (ph == 5'd0) n_low = i_data_byte;
                else raster_go = 1'b1;
                rr = tpbd_pkg::exp5(word[14:10]);
                rg = tpbd_pkg::exp5(word[9:5]);
                rb = tpbd_pkg::exp5(word[4:0]);
                ra = 8'hFF;
            end
            tpbd_pkg::MODE_RGBA4444: begin
                if (ph == 5'd0) n_low = i_data_byte;
                else raster_go = 1'b1;
                rr = tpbd_pkg::exp4(i_data_byte[3:0]);
                rg = tpbd_pkg::exp4(r_low[7:4]);
                rb = tpbd_pkg::exp4(r_low[3:0]);
                ra = tpbd_pkg::exp4(i_data_byte[7:4]);
            end
            tpbd_pkg::MODE_BGRA8888: begin
                if (ph == 5'd0) n_low = i_data_byte;
                else if (ph == 5'd1) n_mid = i_data_byte;
                else if (ph == 5'd2) n_high = i_data_byte;
                else raster_go = 1'b1;
                rr = r_high; rg = r_mid; rb = r_low; ra = i_data_byte;
            end
            tpbd_pkg::MODE_BLOCK, tpbd_pkg::MODE_BLOCK_ALPHA: begin
                if (ph < base) alpha_we = 1'b1;
                else if (off < 5'd4) ep_we[off[1:0]] = 1'b1;
                else block_go = 1'b1;
            end
            default: begin
            end
        endcase

        // raster position
        raster_emit = (col0 < w) && (row0 < h);
        raster_done = ({1'b0, col0} + 1'b1 == {1'b0, w}) && ({1'b0, row0} + 1'b1 == {1'b0, h});

        // block row lanes, stopping at the final pixel of the image
        mask = '0;
        hit  = 1'b0;
        py   = {1'b0, row0} + {{(DW-1){1'b0}}, brow};
        for (int i = 0; i < tpbd_pkg::BLOCK_SIZE; i++) begin
            px = {1'b0, col0} + (DW+1)'(i);
            if (!hit && px < {1'b0, w} && py < {1'b0, h}) begin
                mask[i] = 1'b1;
                if (px + 1'b1 == {1'b0, w} && py + 1'b1 == {1'b0, h}) hit = 1'b1;
            end
        end

        ncol = {1'b0, col0} + (DW+1)'(tpbd_pkg::BLOCK_SIZE);
        if (ncol > (DW+1)'(tpbd_pkg::MAX_DIM)) ncol = (DW+1)'(tpbd_pkg::MAX_DIM);
        nrow = {1'b0, row0} + (DW+1)'(tpbd_pkg::BLOCK_SIZE);
        if (nrow > (DW+1)'(tpbd_pkg::MAX_DIM)) nrow = (DW+1)'(tpbd_pkg::MAX_DIM);

        cnt = '0;
        o_job = '0;
        o_job.x = col0[tpbd_pkg::COORD_W-1:0];
        o_job.y = row0[tpbd_pkg::COORD_W-1:0];

        if (raster_go && !fin0) begin
            cnt = raster_emit ? 3'd1 : 3'd0;
            o_job.c1   = {rr, rg, rb};
            o_job.c2   = {rr, rg, rb};
            o_job.a_lo = ra;
            o_job.a_hi = ra;
            o_job.done = raster_done;
            if (raster_done) begin
                n_fin = 1'b1;
            end else if ({1'b0, col0} + 1'b1 >= {1'b0, w}) begin
                n_col = '0;
                if (row0 < DW'(tpbd_pkg::MAX_DIM)) n_row = row0 + 1'b1;
            end else begin
                n_col = col0 + 1'b1;
            end
        end else if (block_go && !fin0) begin
            cnt = mask[3] ? 3'd4 : mask[2] ? 3'd3 : mask[1] ? 3'd2 : mask[0] ? 3'd1 : 3'd0;
            o_job.y    = py[tpbd_pkg::COORD_W-1:0];
            o_job.c1   = tpbd_pkg::rgb565(r_ep1);
            o_job.c2   = tpbd_pkg::rgb565(r_ep2);
            o_job.idx  = i_data_byte;
            o_job.a_lo = with_alpha ? r_alpha[brow][7:0] : 8'hFF;
            o_job.a_hi = with_alpha ? r_alpha[brow][15:8] : 8'hFF;
            o_job.done = hit;
            n_fin = hit;
            if (off == 5'd7 && !hit) begin
                if (ncol >= {1'b0, w}) begin
                    n_col = '0;
                    n_row = nrow[DW-1:0];
                end else begin
                    n_col = ncol[DW-1:0];
                end
            end
        end

        o_job.last_lane = 2'(cnt - 3'd1);
        o_push = i_accept && (cnt != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0; r_width <= '0; r_height <= '0;
            r_phase <= '0; r_low <= '0; r_mid <= '0; r_high <= '0;
            r_col <= '0; r_row <= '0; r_fin <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tpbd_pkg::CFG_MODE:   r_mode   <= i_cfg_data[2:0];
                    tpbd_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    tpbd_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_low <= n_low; r_mid <= n_mid; r_high <= n_high;
                r_col <= n_col; r_row <= n_row; r_fin <= n_fin;
            end
        end
    end

    // endpoint and alpha stores, valid only once written
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (ep_we[0]) r_ep1[7:0]  <= i_data_byte;
            if (ep_we[1]) r_ep1[15:8] <= i_data_byte;
            if (ep_we[2]) r_ep2[7:0]  <= i_data_byte;
            if (ep_we[3]) r_ep2[15:8] <= i_data_byte;
            if (alpha_we) begin
                if (ph[0]) r_alpha[ph[2:1]][15:8] <= i_data_byte;
                else       r_alpha[ph[2:1]][7:0]  <= i_data_byte;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tpbd_queue.sv
// short job queue between parser and pixel emitter
`timescale 1ns / 1ps
`default_nettype none

module tpbd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tpbd_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output tpbd_pkg::t_job      o_job
);

    tpbd_pkg::t_job                r_mem [tpbd_pkg::QDEPTH];
    logic [tpbd_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [tpbd_pkg::QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == tpbd_pkg::QCNT_W'(tpbd_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

endmodule

`default_nettype wire

// File: hw/rtl/tpbd_back.sv
// pixel emitter: walks the lanes of each job into the output register
`timescale 1ns / 1ps
`default_nettype none

module tpbd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_head_valid,
    input  wire tpbd_pkg::t_job i_head,
    output logic                o_pop,
    input  wire logic           i_stall,
    output logic                o_valid,
    output logic [11:0]         o_pixel_x,
    output logic [11:0]         o_pixel_y,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic [7:0]          o_alpha,
    output logic                o_run_last,
    output logic                o_image_done
);

    logic [1:0]  r_lane;
    logic        r_valid;
    logic        emit, last;
    logic [1:0]  sel;
    logic [23:0] rgb;

    always_comb begin
        emit  = i_head_valid && (!r_valid || !i_stall);
        last  = (r_lane == i_head.last_lane);
        o_pop = emit && last;
        sel   = i_head.idx[{r_lane, 1'b0} +: 2];
        case (sel)
            2'd0:    rgb = i_head.c1;
            2'd1:    rgb = i_head.c2;
            default: rgb = {tpbd_pkg::avg8(i_head.c1[23:16], i_head.c2[23:16]),
                            tpbd_pkg::avg8(i_head.c1[15:8],  i_head.c2[15:8]),
                            tpbd_pkg::avg8(i_head.c1[7:0],   i_head.c2[7:0])};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_lane  <= last ? 2'd0 : r_lane + 1'b1;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_pixel_x    <= i_head.x + {10'd0, r_lane};
            o_pixel_y    <= i_head.y;
            o_red        <= rgb[23:16];
            o_green      <= rgb[15:8];
            o_blue       <= rgb[7:0];
            o_alpha      <= r_lane[1] ? i_head.a_hi : i_head.a_lo;
            o_run_last   <= last;
            o_image_done <= i_head.done && last;
        end
    end

    assign o_valid = r_valid;

    a_lane_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lane != 2'd0 |-> i_head_valid)
        else $error("lane counter running without a queued job");

    a_lane_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> r_lane <= i_head.last_lane)
        else $error("lane counter past last lane of job");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(emit) && r_valid && o_image_done |-> o_run_last)
        else $error("image done on a beat that is not the last of its run");

endmodule

`default_nettype wire

// File: hw/rtl/texture_pixel_block_decoder.sv
// top level of the texture pixel block decoder
// Takes one payload byte per cycle and emits RGBA8 pixels with coordinates. A raster
// item (RGB555, RGBA4444, BGRA8888) yields at most one pixel on its last byte; a block
// index byte yields one block row of up to four pixels, one per unstalled emitter cycle.
// Input accepts one byte per cycle while the four-entry job queue has room, so a stalled
// output or a run of block rows back-pressures the input after four queued jobs. The user
// must write configuration only while idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module texture_pixel_block_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [11:0]      o_pixel_x,
    output logic [11:0]      o_pixel_y,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic             o_run_last,
    output logic             o_image_done
);

    logic           accept, push, pop, full, head_valid;
    tpbd_pkg::t_job job, head;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    tpbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_first_byte(i_first_byte),
        .o_push      (push),
        .o_job       (job)
    );

    tpbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_job   (head)
    );

    tpbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_run_last   (o_run_last),
        .o_image_done (o_image_done)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_texture_pixel_block_decoder.sv
// self-checking testbench for the texture pixel block decoder: byte stream in, checked pixels out
`timescale 1ns / 1ps

module tb_texture_pixel_block_decoder;

    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 120;
    localparam int ITEM_TARGET    = 260;

    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } t_feed_beat;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        run_last;
        logic        image_done;
    } t_pixel;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [1:0]  i_cfg_index  = '0;
    logic [12:0] i_cfg_data   = '0;
    logic        i_valid      = 1'b0;
    logic [7:0]  i_data_byte  = '0;
    logic        i_first_byte = 1'b0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [11:0] o_pixel_x;
    logic [11:0] o_pixel_y;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic        o_run_last;
    logic        o_image_done;

    texture_pixel_block_decoder u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_run_last   (o_run_last),
        .o_image_done (o_image_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // decoder shadow: layout registers and stream state
    logic [2:0]  lay_mode   = '0;
    logic [12:0] lay_width  = '0;
    logic [12:0] lay_height = '0;
    int unsigned dec_phase  = 0;
    logic [7:0]  held_lo    = '0;
    logic [7:0]  held_mid   = '0;
    logic [7:0]  held_hi    = '0;
    logic [15:0] end_a      = '0;
    logic [15:0] end_b      = '0;
    logic [7:0]  alpha_store [8];
    int unsigned col_pos    = 0;
    int unsigned row_pos    = 0;
    logic [1:0]  blk_row    = '0;
    bit          img_finished = 1'b0;
    t_pixel      burst_px [4];
    int          burst_n;

    t_feed_beat  feed_q [$];
    t_pixel      pixel_q [$];

    bit          calm_send  = 1'b0;
    bit          calm_recv  = 1'b0;
    bit          hold_req   = 1'b0;
    bit          hold_taken = 1'b0;
    int unsigned gap_left   = 0;
    int unsigned hold_cnt   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned bytes_in   = 0;
    int unsigned pixels_seen = 0;
    int unsigned mismatches = 0;
    int unsigned layouts    = 0;
    int unsigned bytes_queued = 0;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        int t;
        t = v;
        return 8'((t << 3) | (t >> 2));
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        int t;
        t = v;
        return 8'((t << 2) | (t >> 4));
    endfunction

    function automatic logic [7:0] widen4(input logic [3:0] v);
        int t;
        t = v;
        return 8'((t << 4) | t);
    endfunction

    function automatic logic [7:0] mean_up(input logic [7:0] a, input logic [7:0] b);
        int s;
        s = a + b + 1;
        return 8'(s >> 1);
    endfunction

    function automatic int unsigned clamp_dim(input logic [12:0] v);
        return (v > tpbd_pkg::MAX_DIM) ? tpbd_pkg::MAX_DIM : v;
    endfunction

    function automatic int unsigned bytes_per_item(input logic [2:0] mode);
        case (mode)
            tpbd_pkg::MODE_RGB555:      return 2;
            tpbd_pkg::MODE_RGBA4444:    return 2;
            tpbd_pkg::MODE_BGRA8888:    return 4;
            tpbd_pkg::MODE_BLOCK:       return 8;
            tpbd_pkg::MODE_BLOCK_ALPHA: return 16;
            default:                    return 0;
        endcase
    endfunction

    function automatic string pixel_text(input t_pixel p);
        return $sformatf("x=%0d y=%0d rgba=%02h%02h%02h%02h last=%0b done=%0b",
                         p.x, p.y, p.red, p.green, p.blue, p.alpha, p.run_last,
                         p.image_done);
    endfunction

    task automatic emit_pixel(input int unsigned x, input int unsigned y, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b, input logic [7:0] a,
                              input bit done);
        burst_px[burst_n] = {12'(x), 12'(y), r, g, b, a, 1'b0, done};
        burst_n++;
    endtask

    task automatic raster_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                                input logic [7:0] a);
        int unsigned w;
        int unsigned h;
        bit done;
        w = clamp_dim(lay_width);
        h = clamp_dim(lay_height);
        if (img_finished)
            return;
        done = (col_pos + 1 == w) && (row_pos + 1 == h);
        if (col_pos < w && row_pos < h)
            emit_pixel(col_pos, row_pos, r, g, b, a, done);
        if (done) begin
            img_finished = 1'b1;
            return;
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos < tpbd_pkg::MAX_DIM)
                row_pos++;
        end else begin
            col_pos++;
        end
    endtask

    // works out the pixels one accepted byte gives and queues them
    task automatic decode_byte(input logic [7:0] bt, input logic fb);
        int unsigned len;
        int unsigned p;
        int unsigned base;
        int unsigned off;
        int unsigned w;
        int unsigned h;
        int unsigned px;
        int unsigned py;
        int unsigned ox;
        int          ch;
        int          k;
        logic [15:0] word;
        logic [1:0]  sel;
        logic [7:0]  c1 [3];
        logic [7:0]  c2 [3];
        logic [7:0]  rgb [3];
        logic [7:0]  a;
        bit          with_a;
        bit          done;
        t_pixel      pix;
        burst_n = 0;
        if (fb) begin
            dec_phase = 0;
            col_pos = 0;
            row_pos = 0;
            blk_row = '0;
            img_finished = 1'b0;
        end
        len = bytes_per_item(lay_mode);
        if (len == 0) begin
            dec_phase = 0;
            return;
        end
        if (dec_phase >= len)
            dec_phase = 0;
        p = dec_phase;
        case (lay_mode)
            tpbd_pkg::MODE_RGB555: begin
                if (p == 0) begin
                    held_lo = bt;
                end else begin
                    word = {bt, held_lo};
                    raster_pixel(widen5(word[14:10]), widen5(word[9:5]), widen5(word[4:0]),
                                 8'hFF);
                end
            end
            tpbd_pkg::MODE_RGBA4444: begin
                if (p == 0)
                    held_lo = bt;
                else
                    raster_pixel(widen4(bt[3:0]), widen4(held_lo[7:4]), widen4(held_lo[3:0]),
                                 widen4(bt[7:4]));
            end
            tpbd_pkg::MODE_BGRA8888: begin
                if (p == 0)
                    held_lo = bt;
                else if (p == 1)
                    held_mid = bt;
                else if (p == 2)
                    held_hi = bt;
                else
                    raster_pixel(held_hi, held_mid, held_lo, bt);
            end
            default: begin
                with_a = (lay_mode == tpbd_pkg::MODE_BLOCK_ALPHA);
                base = with_a ? 8 : 0;
                if (p < base) begin
                    alpha_store[p] = bt;
                end else begin
                    off = p - base;
                    case (off)
                        0: end_a[7:0]  = bt;
                        1: end_a[15:8] = bt;
                        2: end_b[7:0]  = bt;
                        3: end_b[15:8] = bt;
                        default: begin
                            blk_row = 2'(off - 4);
                            w = clamp_dim(lay_width);
                            h = clamp_dim(lay_height);
                            c1[0] = widen5(end_a[15:11]);
                            c1[1] = widen6(end_a[10:5]);
                            c1[2] = widen5(end_a[4:0]);
                            c2[0] = widen5(end_b[15:11]);
                            c2[1] = widen6(end_b[10:5]);
                            c2[2] = widen5(end_b[4:0]);
                            for (ox = 0; ox < tpbd_pkg::BLOCK_SIZE && !img_finished; ox++) begin
                                px = col_pos + ox;
                                py = row_pos + blk_row;
                                sel = bt[2*ox +: 2];
                                if (px < w && py < h) begin
                                    for (ch = 0; ch < 3; ch++) begin
                                        if (sel == 2'd0)
                                            rgb[ch] = c1[ch];
                                        else if (sel == 2'd1)
                                            rgb[ch] = c2[ch];
                                        else
                                            rgb[ch] = mean_up(c1[ch], c2[ch]);
                                    end
                                    a = with_a ? alpha_store[blk_row * 2 + ox / 2] : 8'hFF;
                                    done = (px + 1 == w) && (py + 1 == h);
                                    emit_pixel(px, py, rgb[0], rgb[1], rgb[2], a, done);
                                    if (done)
                                        img_finished = 1'b1;
                                end
                            end
                            // move to the next block after its last index byte
                            if (off == 7 && !img_finished) begin
                                col_pos += tpbd_pkg::BLOCK_SIZE;
                                if (col_pos > tpbd_pkg::MAX_DIM)
                                    col_pos = tpbd_pkg::MAX_DIM;
                                if (col_pos >= w) begin
                                    col_pos = 0;
                                    row_pos += tpbd_pkg::BLOCK_SIZE;
                                    if (row_pos > tpbd_pkg::MAX_DIM)
                                        row_pos = tpbd_pkg::MAX_DIM;
                                end
                            end
                        end
                    endcase
                end
            end
        endcase
        dec_phase = (p + 1 >= len) ? 0 : p + 1;
        for (k = 0; k < burst_n; k++) begin
            pix = burst_px[k];
            pix.run_last = (k == burst_n - 1);
            pixel_q.push_back(pix);
        end
    endtask

    // byte driver
    always @(posedge i_clk) begin
        t_feed_beat nb;
        bit take;
        bit offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else begin
            take = i_valid && !o_stall;
            offer = i_valid && !take;
            if (take) begin
                decode_byte(i_data_byte, i_first_byte);
                bytes_in++;
                gap_left = calm_send ? 0 : $urandom_range(0, 11);
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (feed_q.size() != 0) begin
                    nb = feed_q.pop_front();
                    i_data_byte  <= nb.data;
                    i_first_byte <= nb.first;
                    offer = 1'b1;
                end
            end
            i_valid <= offer;
        end
    end

    // pixel monitor and receiver stall
    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        int unsigned next_hold;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_cnt = 0;
        end else begin
            next_hold = hold_cnt;
            if (o_valid && !i_stall) begin
                got = {o_pixel_x, o_pixel_y, o_red, o_green, o_blue, o_alpha,
                       o_run_last, o_image_done};
                pixels_seen++;
                if (pixel_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected pixel %s", pixel_text(got));
                    mismatches++;
                end else begin
                    want = pixel_q.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("pixel mismatch, expected %s", pixel_text(want));
                            $display("                  actual %s", pixel_text(got));
                        end
                        mismatches++;
                    end
                end
                next_hold = calm_recv ? 0 : $urandom_range(0, 11);
            end
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                next_hold = LONG_HOLD;
            end
            if (next_hold > 0) begin
                i_stall <= 1'b1;
                hold_cnt = next_hold - 1;
            end else begin
                i_stall <= 1'b0;
                hold_cnt = 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d pixels outstanding",
                         quiet_cycles, pixel_q.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] d, input bit f);
        t_feed_beat fb;
        fb.data = d;
        fb.first = f;
        feed_q.push_back(fb);
        bytes_queued++;
    endtask

    // sampled away from the rising edge so driver updates are settled
    task automatic wait_drained();
        bit busy;
        busy = 1'b1;
        while (busy) begin
            while (feed_q.size() != 0 || i_valid || pixel_q.size() != 0)
                @(negedge i_clk);
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            busy = (feed_q.size() != 0) || i_valid || (pixel_q.size() != 0);
        end
    endtask

    task automatic set_layout(input logic [2:0] mode, input logic [12:0] w, input logic [12:0] h);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tpbd_pkg::CFG_MODE;
        i_cfg_data  <= {10'd0, mode};
        lay_mode = mode;
        @(posedge i_clk);
        i_cfg_index <= tpbd_pkg::CFG_WIDTH;
        i_cfg_data  <= w;
        lay_width = w;
        @(posedge i_clk);
        i_cfg_index <= tpbd_pkg::CFG_HEIGHT;
        i_cfg_data  <= h;
        lay_height = h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        layouts++;
    endtask

    // one image worth of bytes, sometimes cut short, restarted or run past its end
    task automatic queue_image(input logic [2:0] mode, input logic [12:0] w, input logic [12:0] h,
                               input int unsigned cap, output int unsigned total);
        int unsigned len;
        int unsigned we;
        int unsigned he;
        int unsigned k;
        len = bytes_per_item(mode);
        we = clamp_dim(w);
        he = clamp_dim(h);
        if (mode == tpbd_pkg::MODE_BLOCK || mode == tpbd_pkg::MODE_BLOCK_ALPHA)
            total = ((we + 3) / 4) * ((he + 3) / 4) * len;
        else
            total = we * he * len;
        if (len == 0 || total == 0)
            total = $urandom_range(2, 8);
        else
            total += len * $urandom_range(0, 1);
        if ($urandom_range(0, 4) == 0)
            total = $urandom_range(1, total);
        if (total > cap)
            total = cap;
        for (k = 0; k < total; k++)
            push_byte(8'($urandom_range(0, 255)), (k == 0) || ($urandom_range(0, 39) == 0));
    endtask

    task automatic run_random_phase(input logic [2:0] mode, input logic [12:0] w,
                                    input logic [12:0] h, input int unsigned budget,
                                    input bit squeeze);
        int unsigned n;
        int unsigned cnt;
        set_layout(mode, w, h);
        calm_send = squeeze || ($urandom_range(0, 3) == 0);
        calm_recv = !squeeze && ($urandom_range(0, 3) == 0);
        if (squeeze)
            hold_req = 1'b1;
        n = 0;
        while (n < budget) begin
            queue_image(mode, w, h, budget - n, cnt);
            n += cnt;
        end
    endtask

    initial begin
        logic [2:0]  mode;
        logic [12:0] w;
        logic [12:0] h;
        int unsigned pick;
        foreach (alpha_store[i])
            alpha_store[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // rgb555: black, white with the top bit set, green, then bytes past the image end
        set_layout(tpbd_pkg::MODE_RGB555, 13'd3, 13'd1);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hE0, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);

        set_layout(tpbd_pkg::MODE_RGBA4444, 13'd1, 13'd1);
        push_byte(8'h0F, 1'b1);
        push_byte(8'hF0, 1'b0);

        // bgra8888, then a mode change while the byte phase is beyond the new item length
        set_layout(tpbd_pkg::MODE_BGRA8888, 13'd4, 13'd4);
        push_byte(8'h11, 1'b1);
        push_byte(8'h22, 1'b0);
        push_byte(8'h33, 1'b0);
        push_byte(8'h44, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'hBB, 1'b0);
        push_byte(8'hCC, 1'b0);
        set_layout(tpbd_pkg::MODE_RGB555, 13'd4, 13'd4);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);

        // block: red and blue endpoints, every index, bottom row clipped
        set_layout(tpbd_pkg::MODE_BLOCK, 13'd4, 13'd3);
        push_byte(8'h00, 1'b1);
        push_byte(8'hF8, 1'b0);
        push_byte(8'h1F, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hE4, 1'b0);
        push_byte(8'h1B, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);

        run_random_phase(tpbd_pkg::MODE_BLOCK_ALPHA, 13'd3, 13'd2, 48, 1'b0);
        run_random_phase(tpbd_pkg::MODE_BLOCK, 13'd4096, 13'd4096, 64, 1'b1);
        run_random_phase(tpbd_pkg::MODE_RGB555, 13'd8191, 13'd4096, 16, 1'b0);
        run_random_phase(tpbd_pkg::MODE_BGRA8888, 13'd0, 13'd0, 12, 1'b0);
        run_random_phase(tpbd_pkg::MODE_RGBA4444, 13'd4096, 13'd0, 8, 1'b0);
        run_random_phase(MODE_SPARE_HI, 13'd5, 13'd5, 8, 1'b0);
        run_random_phase(MODE_SPARE_LO, 13'd2, 13'd2, 6, 1'b0);

        while (bytes_queued < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            mode = (pick < 8) ? 3'(pick % 5) : 3'(MODE_SPARE_LO + $urandom_range(0, 2));
            w = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 9));
            h = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 9));
            run_random_phase(mode, w, h, $urandom_range(16, 48), 1'b0);
        end

        wait_drained();
        if (pixel_q.size() != 0) begin
            $display("%0d expected pixels never arrived", pixel_q.size());
            mismatches++;
        end
        $display("%0d bytes fed over %0d register settings, %0d pixels compared",
                 bytes_in, layouts, pixels_seen);
        $display("five encodings plus unused modes, clipping, zero and oversize images, %0d bad",
                 mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
